// ===== design/multi_sensor_ultrasonic_ranger_unit_defines.svh =====
// ============================================================================
// Assertion macros for the multi-sensor ultrasonic ranger
// Concurrent assertion shorthands used by the port checker.
// ============================================================================
`ifndef MULTI_SENSOR_ULTRASONIC_RANGER_UNIT_DEFINES_SVH
`define MULTI_SENSOR_ULTRASONIC_RANGER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MSUR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MSUR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/msur_pkg.sv =====
// ============================================================================
// msur_pkg
// Shared types and constants of the multi-sensor ultrasonic ranger.
// ============================================================================
package msur_pkg;

    localparam int SENSOR_COUNT_DEF = 4;

    localparam int TIME_W  = 16;
    localparam int ECHO_W  = 4;
    localparam int QUERY_W = 2;
    localparam int DIST_W  = 14;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

    localparam logic [CFG_W-1:0] GUARD_RESET   = 16'd20000;
    localparam logic [CFG_W-1:0] TRIGGER_RESET = 16'd10;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd30000;

    // Distance is floor(pulse * 10 / 58) = floor(pulse * 5 / 29). The
    // reciprocal ceil(2^30 / 29) times 5 gives the exact quotient for every
    // 16-bit pulse width, since the rounding error stays below one step.
    localparam int DIST_SHIFT = 30;
    localparam int DIST_MUL_W = 28;
    localparam logic [DIST_MUL_W-1:0] DIST_MUL = 28'd185127905;
    localparam int PROD_W = TIME_W + DIST_MUL_W;

    typedef struct packed {
        logic [TIME_W-1:0]  timestamp_us;
        logic [ECHO_W-1:0]  echo_levels;
        logic [QUERY_W-1:0] query_sensor;
    } msur_item_t;

    typedef struct packed {
        logic [ECHO_W-1:0]  trigger_lines;
        logic [QUERY_W-1:0] current_sensor;
        logic               measure_done;
        logic [QUERY_W-1:0] done_sensor;
        logic               done_valid;
        logic [DIST_W-1:0]  done_distance_mm;
        logic [DIST_W-1:0]  query_distance_mm;
        logic               query_valid;
    } msur_result_t;

endpackage

// ===== design/msur_dist_calc.sv =====
// ============================================================================
// msur_dist_calc
// Converts an echo pulse width in microseconds to a distance in millimeters.
// ============================================================================
module msur_dist_calc (
    input  logic [msur_pkg::TIME_W-1:0] pulse_width,
    output logic [msur_pkg::DIST_W-1:0] dist_out
);
    import msur_pkg::*;

    logic [PROD_W-1:0] prod;

    // One constant multiply replaces the divide by 29.
    assign prod     = PROD_W'(pulse_width) * PROD_W'(DIST_MUL);
    assign dist_out = prod[DIST_SHIFT +: DIST_W];

endmodule

// ===== design/msur_core.sv =====
// ============================================================================
// msur_core
// Phase sequencer, configuration registers and per-sensor distance store.
// ============================================================================
module msur_core #(
    parameter int SENSOR_COUNT = msur_pkg::SENSOR_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [msur_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [msur_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           step_en,
    input  msur_pkg::msur_item_t           item,
    output msur_pkg::msur_result_t         result
);
    import msur_pkg::*;

    localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENSOR_COUNT - 1);

    localparam logic [1:0] PH_GUARD   = 2'd0;
    localparam logic [1:0] PH_TRIGGER = 2'd1;
    localparam logic [1:0] PH_RISE    = 2'd2;
    localparam logic [1:0] PH_FALL    = 2'd3;

    logic [CFG_W-1:0]  guard_reg;
    logic [CFG_W-1:0]  trigger_reg;
    logic [CFG_W-1:0]  timeout_reg;

    logic [1:0]        phase_reg, phase_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic              trig_reg, trig_next;

    logic [SENSOR_COUNT-1:0] valid_reg;
    logic [DIST_W-1:0]       dist_reg [SENSOR_COUNT];

    logic [TIME_W-1:0] elapsed;
    logic [DIST_W-1:0] pulse_mm;
    logic [4:0]        idx_ext;
    logic [4:0]        idx_next_ext;
    logic [4:0]        query_ext;
    logic [IDX_W-1:0]  query_idx;
    logic              query_in_range;
    logic              query_hit;
    logic              echo;
    logic              finish;
    logic              success;
    logic              query_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            guard_reg   <= GUARD_RESET;
            trigger_reg <= TRIGGER_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_GUARD:   guard_reg   <= cfg_wr_data;
                CFG_TRIGGER: trigger_reg <= cfg_wr_data;
                CFG_TIMEOUT: timeout_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign elapsed = item.timestamp_us - start_reg;
    assign idx_ext = 5'(idx_reg);
    // Sensors beyond the four echo inputs always read a low echo.
    assign echo    = (idx_ext < 5'd4) && item.echo_levels[idx_ext[1:0]];

    msur_dist_calc u_dist_calc (
        .pulse_width (elapsed),
        .dist_out    (pulse_mm)
    );

    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        start_next = start_reg;
        trig_next  = trig_reg;
        finish     = 1'b0;
        success    = 1'b0;
        unique case (phase_reg)
            PH_GUARD: begin
                if (elapsed >= guard_reg) begin
                    trig_next  = 1'b1;
                    phase_next = PH_TRIGGER;
                    start_next = item.timestamp_us;
                end
            end
            PH_TRIGGER: begin
                if (elapsed >= trigger_reg) begin
                    trig_next  = 1'b0;
                    phase_next = PH_RISE;
                    start_next = item.timestamp_us;
                end
            end
            PH_RISE: begin
                if (echo) begin
                    phase_next = PH_FALL;
                    start_next = item.timestamp_us;
                end else if (elapsed >= timeout_reg) begin
                    finish = 1'b1;
                end
            end
            PH_FALL: begin
                if (!echo) begin
                    finish  = 1'b1;
                    success = 1'b1;
                end else if (elapsed >= timeout_reg) begin
                    finish = 1'b1;
                end
            end
        endcase
        if (finish) begin
            idx_next   = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
            phase_next = PH_GUARD;
            start_next = item.timestamp_us;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_GUARD;
            idx_reg   <= '0;
            start_reg <= '0;
            trig_reg  <= 1'b0;
            valid_reg <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            start_reg <= start_next;
            trig_reg  <= trig_next;
            if (finish) begin
                valid_reg[idx_reg] <= success;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                dist_reg[i] <= '0;
            end
        end else if (step_en && success) begin
            dist_reg[idx_reg] <= pulse_mm;
        end
    end

    // The query sees this step's store update, so a hit forwards it.
    assign query_ext      = 5'(item.query_sensor);
    assign query_in_range = query_ext < 5'(SENSOR_COUNT);
    assign query_idx      = IDX_W'(query_ext);
    assign query_hit      = finish && (query_idx == idx_reg);
    assign query_ok       = query_in_range && (query_hit ? success : valid_reg[query_idx]);
    assign idx_next_ext   = 5'(idx_next);

    always_comb begin
        result.trigger_lines     = (trig_next && (idx_next_ext < 5'd4))
                                   ? (4'b0001 << idx_next_ext[1:0]) : 4'b0000;
        result.current_sensor    = idx_next_ext[1:0];
        result.measure_done      = finish;
        result.done_sensor       = finish ? idx_ext[1:0] : 2'd0;
        result.done_valid        = success;
        result.done_distance_mm  = success ? pulse_mm : '0;
        result.query_valid       = query_ok;
        result.query_distance_mm = !query_ok ? '0
                                   : (query_hit ? pulse_mm : dist_reg[query_idx]);
    end

endmodule

// ===== design/multi_sensor_ultrasonic_ranger_unit.sv =====
// ============================================================================
// multi_sensor_ultrasonic_ranger_unit
// Round-robin trigger/echo ranging sequencer for several ultrasonic sensors.
// ============================================================================
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  poll    | in        | s_valid / s_ready  | timestamp, echo levels, query
//  result  | out       | m_valid / m_ready  | triggers, status, distances
//  config  | in        | cfg_wr_en          | cfg_wr_index, cfg_wr_data
//
// One request is taken every cycle while s_ready is high; it is registered in
// the input register, and its result in the output register behind m_valid.
// The whole phase step and the distance multiply are combinational.
// Reset clears the phase, the sensor index, all distances and valid bits.
// A stalled result holds; one request waits in the input register, then
// s_ready drops until the result is taken.
// ============================================================================
module multi_sensor_ultrasonic_ranger_unit #(
    parameter int SENSOR_COUNT = msur_pkg::SENSOR_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [msur_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [msur_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [msur_pkg::TIME_W-1:0]    s_timestamp_us,
    input  logic [msur_pkg::ECHO_W-1:0]    s_echo_levels,
    input  logic [msur_pkg::QUERY_W-1:0]   s_query_sensor,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [msur_pkg::ECHO_W-1:0]    m_trigger_lines,
    output logic [msur_pkg::QUERY_W-1:0]   m_current_sensor,
    output logic                           m_measure_done,
    output logic [msur_pkg::QUERY_W-1:0]   m_done_sensor,
    output logic                           m_done_valid,
    output logic [msur_pkg::DIST_W-1:0]    m_done_distance_mm,
    output logic [msur_pkg::DIST_W-1:0]    m_query_distance_mm,
    output logic                           m_query_valid
);
    import msur_pkg::*;

    logic         in_valid_reg;
    msur_item_t   in_item_reg;
    logic         out_valid_reg;
    msur_result_t out_result_reg;
    msur_result_t step_result;
    logic         advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg.timestamp_us <= s_timestamp_us;
            in_item_reg.echo_levels  <= s_echo_levels;
            in_item_reg.query_sensor <= s_query_sensor;
        end
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    msur_core #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .step_en      (advance),
        .item         (in_item_reg),
        .result       (step_result)
    );

    assign m_valid             = out_valid_reg;
    assign m_trigger_lines     = out_result_reg.trigger_lines;
    assign m_current_sensor    = out_result_reg.current_sensor;
    assign m_measure_done      = out_result_reg.measure_done;
    assign m_done_sensor       = out_result_reg.done_sensor;
    assign m_done_valid        = out_result_reg.done_valid;
    assign m_done_distance_mm  = out_result_reg.done_distance_mm;
    assign m_query_distance_mm = out_result_reg.query_distance_mm;
    assign m_query_valid       = out_result_reg.query_valid;

endmodule

// ===== design/msur_checker.sv =====
// ============================================================================
// msur_checker
// Port-level checks of the ranger's result channel, bound to the top level.
// ============================================================================
`include "multi_sensor_ultrasonic_ranger_unit_defines.svh"

module msur_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [msur_pkg::ECHO_W-1:0]    m_trigger_lines,
    input logic [msur_pkg::QUERY_W-1:0]   m_current_sensor,
    input logic                           m_measure_done,
    input logic [msur_pkg::QUERY_W-1:0]   m_done_sensor,
    input logic                           m_done_valid,
    input logic [msur_pkg::DIST_W-1:0]    m_done_distance_mm,
    input logic [msur_pkg::DIST_W-1:0]    m_query_distance_mm,
    input logic                           m_query_valid
);

    // A result that is not taken stays on the port unchanged.
    `MSUR_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_current_sensor) && $stable(m_query_distance_mm) && $stable(m_done_distance_mm), "stalled result changed")

    // At most one trigger line is driven high, the active sensor's.
    `MSUR_ASSERT_NOW(a_trigger_onehot, aclk, aresetn, m_valid, $onehot0(m_trigger_lines), "more than one trigger line high")

    // Without a finished measurement the completion fields are all zero.
    `MSUR_ASSERT_NOW(a_idle_done_zero, aclk, aresetn, m_valid && !m_measure_done, !m_done_valid && (m_done_sensor == 2'd0) && (m_done_distance_mm == 14'd0), "completion fields set without a finished measurement")

    // An invalid query reports no distance.
    `MSUR_ASSERT_NOW(a_query_zero, aclk, aresetn, m_valid && !m_query_valid, m_query_distance_mm == 14'd0, "distance reported for an invalid query")

endmodule

bind multi_sensor_ultrasonic_ranger_unit msur_checker u_msur_checker (.*);

// ===== tb/multi_sensor_ultrasonic_ranger_unit_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// multi_sensor_ultrasonic_ranger_unit_tb
// Self-checking bench for the round-robin ultrasonic ranging sequencer. A
// behavioral copy of the phase sequencer predicts every result; poll requests
// follow a moving microsecond clock with echo levels shaped by the phase of
// the active sensor, under several limit settings and handshake idling mixes.
// ============================================================================
module multi_sensor_ultrasonic_ranger_unit_tb;
    import msur_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000;

    typedef enum logic [1:0] {PH_GUARD, PH_TRIGGER, PH_RISE, PH_FALL} ranger_phase_e;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_wr_index;
    logic [CFG_W-1:0]     cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [TIME_W-1:0]    s_timestamp_us;
    logic [ECHO_W-1:0]    s_echo_levels;
    logic [QUERY_W-1:0]   s_query_sensor;
    logic                 m_valid;
    logic                 m_ready;
    logic [ECHO_W-1:0]    m_trigger_lines;
    logic [QUERY_W-1:0]   m_current_sensor;
    logic                 m_measure_done;
    logic [QUERY_W-1:0]   m_done_sensor;
    logic                 m_done_valid;
    logic [DIST_W-1:0]    m_done_distance_mm;
    logic [DIST_W-1:0]    m_query_distance_mm;
    logic                 m_query_valid;

    // Behavioral copy of the sequencer state and its limit registers.
    logic [CFG_W-1:0]   guard_cfg;
    logic [CFG_W-1:0]   trig_cfg;
    logic [CFG_W-1:0]   timeout_cfg;
    ranger_phase_e      seq_phase;
    logic [QUERY_W-1:0] seq_sensor;
    logic [TIME_W-1:0]  phase_t0;
    logic               trig_level;
    logic [DIST_W-1:0]  dist_mem [4];
    logic [3:0]         dist_ok;

    msur_result_t pending_readings [$];
    logic [TIME_W-1:0] clock_us;
    int src_idle_pct;
    int sink_idle_pct;
    int failures;
    int polls_taken;
    int results_checked;
    int ranges_ok;
    int ranges_timed_out;
    int stall_cycles;

    multi_sensor_ultrasonic_ranger_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_index       (cfg_wr_index),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_timestamp_us     (s_timestamp_us),
        .s_echo_levels      (s_echo_levels),
        .s_query_sensor     (s_query_sensor),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_trigger_lines    (m_trigger_lines),
        .m_current_sensor   (m_current_sensor),
        .m_measure_done     (m_measure_done),
        .m_done_sensor      (m_done_sensor),
        .m_done_valid       (m_done_valid),
        .m_done_distance_mm (m_done_distance_mm),
        .m_query_distance_mm(m_query_distance_mm),
        .m_query_valid      (m_query_valid)
    );

    always #1 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Advances the sequencer copy by one poll request and returns its result.
    function automatic msur_result_t step_ranger(input msur_item_t req);
        msur_result_t      r;
        logic [TIME_W-1:0] elapsed;
        logic [1:0]        idx;
        logic              echo_hi;
        logic              finished;
        logic              success;
        logic [31:0]       pulse_mm;
        r        = '0;
        idx      = seq_sensor;
        echo_hi  = req.echo_levels[idx];
        elapsed  = req.timestamp_us - phase_t0;
        finished = 1'b0;
        success  = 1'b0;
        pulse_mm = ({16'd0, elapsed} * 32'd10) / 32'd58;
        case (seq_phase)
            PH_GUARD: begin
                if (elapsed >= guard_cfg) begin
                    trig_level = 1'b1;
                    seq_phase  = PH_TRIGGER;
                    phase_t0   = req.timestamp_us;
                end
            end
            PH_TRIGGER: begin
                if (elapsed >= trig_cfg) begin
                    trig_level = 1'b0;
                    seq_phase  = PH_RISE;
                    phase_t0   = req.timestamp_us;
                end
            end
            PH_RISE: begin
                // A rising echo wins over an expired timeout.
                if (echo_hi) begin
                    seq_phase = PH_FALL;
                    phase_t0  = req.timestamp_us;
                end else if (elapsed >= timeout_cfg) begin
                    finished = 1'b1;
                end
            end
            default: begin
                if (!echo_hi) begin
                    finished = 1'b1;
                    success  = 1'b1;
                end else if (elapsed >= timeout_cfg) begin
                    finished = 1'b1;
                end
            end
        endcase
        if (finished) begin
            r.measure_done = 1'b1;
            r.done_sensor  = idx;
            r.done_valid   = success;
            if (success) begin
                r.done_distance_mm = pulse_mm[DIST_W-1:0];
                dist_mem[idx]      = pulse_mm[DIST_W-1:0];
            end
            dist_ok[idx] = success;
            seq_sensor   = seq_sensor + 2'd1;
            seq_phase    = PH_GUARD;
            phase_t0     = req.timestamp_us;
        end
        r.trigger_lines  = trig_level ? (4'd1 << seq_sensor) : 4'd0;
        r.current_sensor = seq_sensor;
        if (dist_ok[req.query_sensor]) begin
            r.query_distance_mm = dist_mem[req.query_sensor];
            r.query_valid       = 1'b1;
        end
        return r;
    endfunction

    // Builds a poll request that mostly follows the running clock, with echo
    // levels that let the active sensor rise and fall like a real reflection.
    function automatic msur_item_t make_poll(input int step_max);
        msur_item_t        req;
        logic [CFG_W-1:0]  lim;
        int                roll;
        logic              echo_hi;
        case (seq_phase)
            PH_GUARD:   lim = guard_cfg;
            PH_TRIGGER: lim = trig_cfg;
            default:    lim = timeout_cfg;
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            req.timestamp_us = 16'($urandom);
        end else if (roll < 14) begin
            req.timestamp_us = phase_t0 + lim - 16'($urandom_range(0, 1));
        end else begin
            req.timestamp_us = clock_us + 16'($urandom_range(0, step_max));
        end
        clock_us = req.timestamp_us;
        req.echo_levels = 4'($urandom);
        if ($urandom_range(0, 9) != 0) begin
            case (seq_phase)
                PH_RISE: echo_hi = ($urandom_range(0, 99) < 30);
                PH_FALL: echo_hi = ($urandom_range(0, 99) < 75);
                default: echo_hi = 1'($urandom_range(0, 1));
            endcase
            req.echo_levels[seq_sensor] = echo_hi;
        end
        req.query_sensor = 2'($urandom_range(0, 3));
        return req;
    endfunction

    // All stimulus tasks start and end just after a falling edge.
    task automatic send_poll(input msur_item_t req);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_timestamp_us <= req.timestamp_us;
        s_echo_levels  <= req.echo_levels;
        s_query_sensor <= req.query_sensor;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic poll_at(input logic [TIME_W-1:0] offset, input logic [ECHO_W-1:0] echoes,
                           input logic [QUERY_W-1:0] q);
        msur_item_t req;
        req.timestamp_us = phase_t0 + offset;
        req.echo_levels  = echoes;
        req.query_sensor = q;
        clock_us         = req.timestamp_us;
        send_poll(req);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_readings.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val,
                             input bit last);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        case (idx)
            CFG_GUARD:   guard_cfg   = val;
            CFG_TRIGGER: trig_cfg    = val;
            CFG_TIMEOUT: timeout_cfg = val;
            default: ;
        endcase
        @(negedge aclk);
        if (last) cfg_wr_en <= 1'b0;
    endtask

    task automatic set_limits(input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] t,
                              input logic [CFG_W-1:0] o);
        write_reg(CFG_GUARD, g, 1'b0);
        write_reg(CFG_TRIGGER, t, 1'b0);
        write_reg(CFG_TIMEOUT, o, 1'b1);
    endtask

    // Reset limits: one full cycle over all four sensors with a maximal pulse,
    // a rise timeout, a fall timeout, and a rise landing exactly on the timeout.
    task automatic test_reset_sequencing();
        poll_at(16'd0, 4'h0, 2'd0);
        poll_at(16'd19999, 4'hE, 2'd1);
        poll_at(16'd20000, 4'h0, 2'd2);
        poll_at(16'd10, 4'h0, 2'd0);
        poll_at(16'd100, 4'hE, 2'd0);
        poll_at(16'd100, 4'h1, 2'd0);
        // The echo falls one tick before the clock wraps back to the start.
        poll_at(16'd65535, 4'h0, 2'd0);
        poll_at(16'd20000, 4'h0, 2'd1);
        poll_at(16'd10, 4'h0, 2'd1);
        poll_at(16'd30000, 4'hD, 2'd1);
        poll_at(16'd20000, 4'h0, 2'd2);
        poll_at(16'd10, 4'h0, 2'd2);
        poll_at(16'd5, 4'h4, 2'd2);
        poll_at(16'd30000, 4'hF, 2'd2);
        poll_at(16'd20000, 4'h0, 2'd3);
        poll_at(16'd10, 4'h0, 2'd3);
        poll_at(16'd30000, 4'h8, 2'd3);
        poll_at(16'd0, 4'h7, 2'd3);
    endtask

    // With every limit at zero, each phase expires on its first request.
    task automatic test_zero_limits();
        drain_results();
        write_reg(CFG_GUARD, 16'd0, 1'b0);
        write_reg(CFG_TRIGGER, 16'd0, 1'b0);
        write_reg(CFG_TIMEOUT, 16'd0, 1'b0);
        write_reg(CFG_UNUSED, 16'hFFFF, 1'b1);
        poll_at(16'd0, 4'h0, 2'd0);
        poll_at(16'd0, 4'h0, 2'd0);
        poll_at(16'd0, 4'hE, 2'd0);
        poll_at(16'd0, 4'h0, 2'd1);
        poll_at(16'd0, 4'h0, 2'd1);
        poll_at(16'd0, 4'h2, 2'd1);
        poll_at(16'd0, 4'hF, 2'd3);
    endtask

    task automatic test_full_scale_limits();
        drain_results();
        set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
        poll_at(16'd65534, 4'hF, 2'd1);
        poll_at(16'd65535, 4'h0, 2'd2);
    endtask

    task automatic test_random_polls(input int n_sets, input int per_set, input int src_pct,
                                     input int sink_pct);
        int step_max;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int s = 0; s < n_sets; s++) begin
            drain_results();
            case ($urandom_range(0, 5))
                0: set_limits(16'd0, 16'd0, 16'($urandom_range(0, 3)));
                1: set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: set_limits(16'($urandom_range(0, 60)), 16'($urandom_range(0, 20)),
                                    16'($urandom_range(1, 400)));
            endcase
            step_max = $urandom_range(1, 50);
            for (int n = 0; n < per_set; n++) begin
                // Now and then the sender holds off until every result is back.
                if ($urandom_range(0, 59) == 0) drain_results();
                send_poll(make_poll(step_max));
            end
        end
    endtask

    always @(posedge aclk) begin : poll_monitor
        msur_item_t   req;
        msur_result_t got;
        msur_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                req.timestamp_us = s_timestamp_us;
                req.echo_levels  = s_echo_levels;
                req.query_sensor = s_query_sensor;
                pending_readings.push_back(step_ranger(req));
                polls_taken++;
            end
            if (m_valid && m_ready) begin
                got.trigger_lines     = m_trigger_lines;
                got.current_sensor    = m_current_sensor;
                got.measure_done      = m_measure_done;
                got.done_sensor       = m_done_sensor;
                got.done_valid        = m_done_valid;
                got.done_distance_mm  = m_done_distance_mm;
                got.query_distance_mm = m_query_distance_mm;
                got.query_valid       = m_query_valid;
                if (pending_readings.size() == 0) begin
                    failures++;
                    if (failures <= 10) $display("Result arrived with no request pending");
                end else begin
                    want = pending_readings.pop_front();
                    results_checked++;
                    if (want.measure_done) begin
                        if (want.done_valid) ranges_ok++;
                        else ranges_timed_out++;
                    end
                    if (got !== want) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("Mismatch on result %0d:", results_checked);
                            $display("  expected trig=%h cur=%0d done=%b sensor=%0d ok=%b dist=%0d q=%0d/%b",
                                     want.trigger_lines, want.current_sensor, want.measure_done,
                                     want.done_sensor, want.done_valid, want.done_distance_mm,
                                     want.query_distance_mm, want.query_valid);
                            $display("  actual   trig=%h cur=%0d done=%b sensor=%0d ok=%b dist=%0d q=%0d/%b",
                                     got.trigger_lines, got.current_sensor, got.measure_done,
                                     got.done_sensor, got.done_valid, got.done_distance_mm,
                                     got.query_distance_mm, got.query_valid);
                        end
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    initial begin
        aclk             = 1'b0;
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_index     = '0;
        cfg_wr_data      = '0;
        s_valid          = 1'b0;
        s_timestamp_us   = '0;
        s_echo_levels    = '0;
        s_query_sensor   = '0;
        m_ready          = 1'b0;
        guard_cfg        = GUARD_RESET;
        trig_cfg         = TRIGGER_RESET;
        timeout_cfg      = TIMEOUT_RESET;
        seq_phase        = PH_GUARD;
        seq_sensor       = '0;
        phase_t0         = '0;
        trig_level       = 1'b0;
        dist_ok          = '0;
        for (int i = 0; i < 4; i++) dist_mem[i] = '0;
        clock_us         = '0;
        src_idle_pct     = 19;
        sink_idle_pct    = 56;
        failures         = 0;
        polls_taken      = 0;
        results_checked  = 0;
        ranges_ok        = 0;
        ranges_timed_out = 0;
        stall_cycles     = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_sequencing();
        test_zero_limits();
        test_full_scale_limits();
        test_random_polls(3, 90, 19, 56);
        test_random_polls(3, 90, 56, 19);
        test_random_polls(3, 90, 0, 0);

        drain_results();
        repeat (8) @(negedge aclk);
        $display("Run covered %0d poll requests and %0d checked results.",
                 polls_taken, results_checked);
        $display("Measurements seen: %0d ranged, %0d timed out, across zero to full-scale limits.",
                 ranges_ok, ranges_timed_out);
        if (failures == 0 && pending_readings.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
